[hdl/rsc_encoder_with_tail_unit_macros.svh]
// assertion macros for the rsc encoder with tail unit
`ifndef RSC_ENCODER_WITH_TAIL_UNIT_MACROS_SVH
`define RSC_ENCODER_WITH_TAIL_UNIT_MACROS_SVH

// same-cycle implication
`define RSCE_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rsce: same-cycle check failed");

// next-cycle implication
`define RSCE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rsce: next-cycle check failed");

`endif

[hdl/rsce_pkg.sv]
// shared types, constants and helpers of the rsc encoder with tail
package rsce_pkg;

    localparam int STATE_BITS = 8;
    localparam int LEN_W      = 4;
    localparam int TAPS_W     = 8;
    localparam int IDX_W      = 8;
    localparam int DATA_W     = 8;

    localparam logic [TAPS_W-1:0] TAPS_RESET = 8'd123;
    localparam logic [LEN_W-1:0]  K_RESET    = 4'd7;

    localparam logic [IDX_W-1:0] CFG_IDX_TAPS = 8'd0;
    localparam logic [IDX_W-1:0] CFG_IDX_K    = 8'd1;

    typedef struct packed {
        logic [TAPS_W-1:0] taps;
        logic [LEN_W-1:0]  mem_len;
    } cfg_t;

    typedef struct packed {
        logic data_bit;
        logic end_of_message;
    } in_item_t;

    typedef struct packed {
        logic code_bit;
        logic is_tail;
        logic last_of_block;
    } out_item_t;

    // low mem_len bits set, mem_len in 1..STATE_BITS
    function automatic logic [STATE_BITS-1:0] state_mask(input logic [LEN_W-1:0] mem_len);
        logic [STATE_BITS-1:0] ones;
        logic [LEN_W-1:0]      sh;
        ones = '1;
        sh   = LEN_W'(STATE_BITS) - mem_len;
        return ones >> sh;
    endfunction

endpackage

[hdl/rsce_cfg.sv]
// configuration registers and memory length decode
module rsce_cfg
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [rsce_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rsce_pkg::DATA_W-1:0] cfg_data,
    output rsce_pkg::cfg_t           cfg
);
    import rsce_pkg::*;

    logic [TAPS_W-1:0] taps_reg;
    logic [LEN_W-1:0]  k_reg;
    logic [LEN_W-1:0]  mem_len;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taps_reg <= TAPS_RESET;
            k_reg    <= K_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_IDX_TAPS)
            begin
                taps_reg <= cfg_data[TAPS_W-1:0];
            end
            else if (cfg_index == CFG_IDX_K)
            begin
                k_reg <= cfg_data[LEN_W-1:0];
            end
        end
    end

    // saturate k-1 to 1..STATE_BITS
    always_comb
    begin
        if (k_reg < LEN_W'(2))
        begin
            mem_len = LEN_W'(1);
        end
        else if (k_reg - LEN_W'(1) > LEN_W'(STATE_BITS))
        begin
            mem_len = LEN_W'(STATE_BITS);
        end
        else
        begin
            mem_len = k_reg - LEN_W'(1);
        end
    end

    assign cfg.taps    = taps_reg;
    assign cfg.mem_len = mem_len;

endmodule

[hdl/rsce_in_reg.sv]
// input holding register for one request
module rsce_in_reg
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rsce_pkg::DATA_W-1:0] s_axis_tdata,
    input  logic                        s_axis_tlast,
    input  logic                        consume,
    output logic                        item_valid,
    output rsce_pkg::in_item_t          item
);
    import rsce_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    logic     accept;

    assign s_axis_tready = !valid_reg || consume;
    assign accept        = s_axis_tvalid && s_axis_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (consume)
        begin
            valid_next = 1'b0;
        end
        if (accept)
        begin
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg.data_bit       <= s_axis_tdata[0];
            item_reg.end_of_message <= s_axis_tlast;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

[hdl/rsce_core.sv]
// shift state, tail counter and result register
module rsce_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  rsce_pkg::cfg_t     cfg,
    input  logic               item_valid,
    input  rsce_pkg::in_item_t item,
    output logic               consume,
    output logic               out_valid,
    input  logic               out_ready,
    output rsce_pkg::out_item_t out_item
);
    import rsce_pkg::*;

    logic [STATE_BITS-1:0] state_reg;
    logic [STATE_BITS-1:0] state_next;
    logic [LEN_W-1:0]      tail_cnt_reg;
    logic [LEN_W-1:0]      tail_cnt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    out_item_t             out_item_reg;
    out_item_t             out_item_next;

    logic [STATE_BITS-1:0] mask;
    logic [STATE_BITS-1:0] st;
    logic                  par;
    logic                  fb;
    logic                  out_load;
    logic                  tail_active;

    assign mask        = state_mask(cfg.mem_len);
    assign st          = state_reg & mask;
    assign par         = ^(st & cfg.taps[STATE_BITS-1:0]);
    assign fb          = item.data_bit ^ par;
    assign out_load    = !out_valid_reg || out_ready;
    assign tail_active = (tail_cnt_reg != '0);
    assign consume     = item_valid && !tail_active && out_load;

    always_comb
    begin
        state_next     = state_reg;
        tail_cnt_next  = tail_cnt_reg;
        out_valid_next = out_valid_reg;
        out_item_next  = out_item_reg;
        if (out_load)
        begin
            out_valid_next = 1'b0;
        end
        if (out_load && tail_active)
        begin
            out_item_next.code_bit      = par;
            out_item_next.is_tail       = 1'b1;
            out_item_next.last_of_block = (tail_cnt_reg == LEN_W'(1));
            out_valid_next              = 1'b1;
            state_next                  = st >> 1;
            tail_cnt_next               = tail_cnt_reg - LEN_W'(1);
        end
        else if (consume)
        begin
            out_item_next.code_bit      = item.data_bit;
            out_item_next.is_tail       = 1'b0;
            out_item_next.last_of_block = 1'b0;
            out_valid_next              = 1'b1;
            state_next = ((st >> 1) | (STATE_BITS'(fb) << (cfg.mem_len - LEN_W'(1)))) & mask;
            tail_cnt_next = item.end_of_message ? cfg.mem_len : '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= '0;
            tail_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            tail_cnt_reg  <= tail_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

[hdl/rsc_encoder_with_tail_unit.sv]
// top level of the rsc encoder with tail
//
// channel   dir  handshake                      payload
// s_axis    in   s_axis_tvalid / s_axis_tready  tdata[0] data_bit, tlast end_of_message
// m_axis    out  m_axis_tvalid / m_axis_tready  tdata[0] code_bit, tuser[0] is_tail,
//                                               tlast last_of_block
// cfg       in   cfg_valid / cfg_ready          cfg_index, cfg_data
//
// one request per cycle unless a tail is pending or m_axis stalls; a request with tlast is
// followed by m tail results, m = k-1 held to 1..8, one per cycle unless stalled, during
// which no request leaves the input register; requests pass the input and then the result
// register; an empty input register takes a request while a result waits on m_axis; reset
// clears the shift state, the tail counter and both valid flags; cfg_ready stays high
module rsc_encoder_with_tail_unit
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [rsce_pkg::DATA_W-1:0] s_axis_tdata,   // [0] data_bit, rest zero
    input  logic                        s_axis_tlast,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [rsce_pkg::DATA_W-1:0] m_axis_tdata,   // [0] code_bit, rest zero
    output logic                        m_axis_tlast,
    output logic [0:0]                  m_axis_tuser,   // [0] is_tail
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [rsce_pkg::IDX_W-1:0]  cfg_index,
    input  logic [rsce_pkg::DATA_W-1:0] cfg_data
);
    import rsce_pkg::*;

    cfg_t      cfg;
    logic      consume;
    logic      item_valid;
    in_item_t  item;
    out_item_t out_item;

    rsce_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    rsce_in_reg u_in_reg
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .consume       (consume),
        .item_valid    (item_valid),
        .item          (item)
    );

    rsce_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (item_valid),
        .item       (item),
        .consume    (consume),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = {{(DATA_W-1){1'b0}}, out_item.code_bit};
    assign m_axis_tuser = out_item.is_tail;
    assign m_axis_tlast = out_item.last_of_block;

endmodule

[hdl/rsce_checker.sv]
// port checker for the rsc encoder with tail, bound to the top level
`include "rsc_encoder_with_tail_unit_macros.svh"

module rsce_checker
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    input  logic [rsce_pkg::DATA_W-1:0] m_axis_tdata,
    input  logic                        m_axis_tlast,
    input  logic [0:0]                  m_axis_tuser
);
    import rsce_pkg::*;

    // block end only on a tail bit
    `RSCE_ASSERT_NOW(a_last_is_tail, clk, rst_n, m_axis_tvalid && m_axis_tlast, m_axis_tuser[0])

    // padding bits of the result stay zero
    `RSCE_ASSERT_NOW(a_pad_zero, clk, rst_n, m_axis_tvalid, m_axis_tdata[DATA_W-1:1] == '0)

    // stalled result holds
    `RSCE_ASSERT_NEXT(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // an accepted tail bit that is not last is followed by more tail output
    `RSCE_ASSERT_NEXT(a_tail_continues, clk, rst_n,
        m_axis_tvalid && m_axis_tready && m_axis_tuser[0] && !m_axis_tlast,
        m_axis_tvalid && m_axis_tuser[0])

endmodule

bind rsc_encoder_with_tail_unit rsce_checker u_rsce_checker (.*);
